// ===== src/jpp_pkg.sv =====
package jpp_pkg;

	localparam int MAX_NEST = 8;
	localparam int IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
	localparam logic [3:0] NEST_LIMIT = 4'(MAX_NEST);

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic OP_TEXT = 1'b0;
	localparam logic OP_END = 1'b1;

	// Output segments of one request, emitted in bit order.
	localparam int SEG_RESOLVE = 0;   // newline and indent for a resolved opener
	localparam int SEG_PRE = 1;       // newline and indent ahead of the byte
	localparam int SEG_CHAR = 2;      // the byte itself
	localparam int SEG_POST = 3;      // newline and indent after the byte
	localparam int SEG_SPACE = 4;     // one space after a colon
	localparam int SEG_N = 5;

	typedef struct packed {
		logic [SEG_N-1:0] seg_mask;
		logic [3:0] lvl_a;
		logic [3:0] lvl_b;
		logic [7:0] ch;
		logic err;
	} cmd_t;

endpackage

// ===== src/jpp_front.sv =====
module jpp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [7:0] in_byte,
	output logic cmd_valid,
	input logic cmd_ready,
	output jpp_pkg::cmd_t cmd
);

	logic inside_string_q, escape_pending_q, open_pending_q, pending_is_brace_q;
	logic [3:0] indent_q, open_count_q;
	logic expanded_stack_q [jpp_pkg::MAX_NEST];

	logic accept, emits, blank;
	logic str_d, esc_d, pend_d, brace_d;
	logic [3:0] indent_d, count_d, cnt1, lvl1;
	logic push_en, push_exp, top_exp;
	logic [3:0] top_idx;

	assign in_ready = cmd_ready;
	assign accept = in_valid && in_ready;
	assign cmd_valid = accept && emits;

	assign blank = (in_byte == jpp_pkg::CH_SP) || (in_byte == jpp_pkg::CH_TAB) ||
		(in_byte == jpp_pkg::CH_LF) || (in_byte == jpp_pkg::CH_VT) ||
		(in_byte == jpp_pkg::CH_FF) || (in_byte == jpp_pkg::CH_CR);

	always_comb begin
		str_d = inside_string_q;
		esc_d = escape_pending_q;
		pend_d = open_pending_q;
		brace_d = pending_is_brace_q;
		indent_d = indent_q;
		count_d = open_count_q;
		cnt1 = open_count_q;
		lvl1 = indent_q;
		push_en = 1'b0;
		push_exp = 1'b0;
		top_idx = open_count_q - 4'd1;
		top_exp = 1'b0;
		emits = 1'b1;
		cmd = '0;
		cmd.ch = in_byte;
		if (op == jpp_pkg::OP_END) begin
			// A pending opener is closed out as expanded, then one newline.
			if (open_pending_q) begin
				cmd.seg_mask[jpp_pkg::SEG_RESOLVE] = 1'b1;
				cmd.lvl_a = indent_q + 4'd1;
			end
			cmd.seg_mask[jpp_pkg::SEG_PRE] = 1'b1;
			cmd.lvl_b = 4'd0;
			str_d = 1'b0;
			esc_d = 1'b0;
			pend_d = 1'b0;
			brace_d = 1'b0;
			indent_d = 4'd0;
			count_d = 4'd0;
		end else if (inside_string_q) begin
			cmd.seg_mask[jpp_pkg::SEG_CHAR] = 1'b1;
			if (escape_pending_q) begin
				esc_d = 1'b0;
			end else if (in_byte == jpp_pkg::CH_BSLASH) begin
				esc_d = 1'b1;
			end else if (in_byte == jpp_pkg::CH_QUOTE) begin
				str_d = 1'b0;
			end
		end else if (blank) begin
			emits = 1'b0;
		end else begin
			if (open_pending_q) begin
				push_en = 1'b1;
				push_exp = pending_is_brace_q ? (in_byte != jpp_pkg::CH_RBRACE)
					: (in_byte != jpp_pkg::CH_RBRACK);
				cnt1 = open_count_q + 4'd1;
				lvl1 = indent_q + {3'd0, push_exp};
				cmd.seg_mask[jpp_pkg::SEG_RESOLVE] = push_exp;
				cmd.lvl_a = lvl1;
				pend_d = 1'b0;
				brace_d = 1'b0;
			end
			count_d = cnt1;
			indent_d = lvl1;
			cmd.seg_mask[jpp_pkg::SEG_CHAR] = 1'b1;
			priority if (in_byte == jpp_pkg::CH_QUOTE) begin
				str_d = 1'b1;
			end else if (in_byte == jpp_pkg::CH_LBRACE || in_byte == jpp_pkg::CH_LBRACK) begin
				if (cnt1 >= jpp_pkg::NEST_LIMIT) begin
					cmd.err = 1'b1;
				end else begin
					pend_d = 1'b1;
					brace_d = (in_byte == jpp_pkg::CH_LBRACE);
				end
			end else if (in_byte == jpp_pkg::CH_RBRACE || in_byte == jpp_pkg::CH_RBRACK) begin
				if (cnt1 == 4'd0) begin
					cmd.err = 1'b1;
				end else begin
					count_d = cnt1 - 4'd1;
					// The entry just pushed in this request is not in the stack yet.
					top_exp = push_en ? push_exp : expanded_stack_q[top_idx[jpp_pkg::IDX_W-1:0]];
					if (top_exp) begin
						indent_d = (lvl1 != 4'd0) ? lvl1 - 4'd1 : 4'd0;
						cmd.seg_mask[jpp_pkg::SEG_PRE] = 1'b1;
						cmd.lvl_b = indent_d;
					end
				end
			end else if (in_byte == jpp_pkg::CH_COMMA) begin
				cmd.seg_mask[jpp_pkg::SEG_POST] = 1'b1;
				cmd.lvl_b = lvl1;
			end else if (in_byte == jpp_pkg::CH_COLON) begin
				cmd.seg_mask[jpp_pkg::SEG_SPACE] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_string_q <= 1'b0;
			escape_pending_q <= 1'b0;
			open_pending_q <= 1'b0;
			pending_is_brace_q <= 1'b0;
			indent_q <= 4'd0;
			open_count_q <= 4'd0;
		end else if (accept) begin
			inside_string_q <= str_d;
			escape_pending_q <= esc_d;
			open_pending_q <= pend_d;
			pending_is_brace_q <= brace_d;
			indent_q <= indent_d;
			open_count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push_en && op == jpp_pkg::OP_TEXT) begin
			expanded_stack_q[open_count_q[jpp_pkg::IDX_W-1:0]] <= push_exp;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) open_count_q <= jpp_pkg::NEST_LIMIT)
		else $error("nesting count beyond the stack depth");
	assert property (@(posedge clk) disable iff (!arst_n) indent_q <= open_count_q)
		else $error("indent level exceeds the number of open containers");
	assert property (@(posedge clk) disable iff (!arst_n)
		open_pending_q |-> (open_count_q < jpp_pkg::NEST_LIMIT && !inside_string_q))
		else $error("pending opener with no room on the stack");

endmodule

// ===== src/jpp_queue.sv =====
module jpp_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input jpp_pkg::cmd_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output jpp_pkg::cmd_t rd_data
);

	jpp_pkg::cmd_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic do_wr, do_rd;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data = entry_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== src/jpp_back.sv =====
module jpp_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input jpp_pkg::cmd_t cmd,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic last,
	output logic nest_error
);

	jpp_pkg::cmd_t cmd_q;
	logic [jpp_pkg::SEG_N-1:0] mask_q, sel, mask_nxt;
	logic [4:0] cnt_q, limit;
	logic out_valid_q, last_q, err_q;
	logic [7:0] byte_q, byte_d;
	logic busy, advance, is_nl, seg_done, last_d;
	logic [3:0] lvl;

	assign busy = (mask_q != '0);
	assign advance = !out_valid_q || out_ready;
	assign cmd_ready = !busy;

	// Lowest pending segment goes first.
	assign sel = mask_q & ~(mask_q - {{(jpp_pkg::SEG_N-1){1'b0}}, 1'b1});
	assign is_nl = sel[jpp_pkg::SEG_RESOLVE] || sel[jpp_pkg::SEG_PRE] || sel[jpp_pkg::SEG_POST];
	assign lvl = sel[jpp_pkg::SEG_RESOLVE] ? cmd_q.lvl_a : cmd_q.lvl_b;
	assign limit = {lvl, 1'b0};
	assign seg_done = !is_nl || (cnt_q == limit);
	assign mask_nxt = seg_done ? (mask_q & ~sel) : mask_q;
	assign last_d = seg_done && (mask_nxt == '0);

	always_comb begin
		if (is_nl) begin
			byte_d = (cnt_q == 5'd0) ? jpp_pkg::CH_LF : jpp_pkg::CH_SP;
		end else if (sel[jpp_pkg::SEG_CHAR]) begin
			byte_d = cmd_q.ch;
		end else begin
			byte_d = jpp_pkg::CH_SP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cnt_q <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy) begin
				if (cmd_valid) begin
					mask_q <= cmd.seg_mask;
					cnt_q <= 5'd0;
				end
				if (advance) out_valid_q <= 1'b0;
			end else if (advance) begin
				mask_q <= mask_nxt;
				cnt_q <= seg_done ? 5'd0 : cnt_q + 5'd1;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && cmd_valid) cmd_q <= cmd;
		if (busy && advance) begin
			byte_q <= byte_d;
			last_q <= last_d;
			err_q <= cmd_q.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = byte_q;
	assign last = last_q;
	assign nest_error = err_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(busy && advance && last_d) |=> (!busy && out_valid_q && last_q))
		else $error("final byte of a request did not end the request");

endmodule

// ===== src/json_pretty_printer.sv =====
// A request passes through the queue entry and the back end's command register before
// its first byte reaches the output register. The back end gives one output byte per
// cycle while out_ready does not stall it, and takes a new request only after the last
// byte of the previous one. A two-entry queue lets the front keep taking bytes meanwhile.
// Reset: arst_n clears all control state at once; the nesting stack is not cleared.
module json_pretty_printer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [7:0] in_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic last,
	output logic nest_error
);

	jpp_pkg::cmd_t f_cmd, b_cmd;
	logic f_valid, f_ready, b_valid, b_ready;

	jpp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.in_byte(in_byte),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd(f_cmd)
	);

	jpp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data(f_cmd),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data(b_cmd)
	);

	jpp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd(b_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last(last),
		.nest_error(nest_error)
	);

endmodule
